// ===== design/psdt_pkg.sv =====
// psdt_pkg: types, field widths and constants shared by the proportional-share gate.
// No dependencies; compiled first.
package psdt_pkg;

	// operation codes of a command beat
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_END     = 2'd1,
		OP_CONSUME = 2'd2,
		OP_CHECK   = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_PERIOD   = 3'd0,
		CFG_PRIO_VM1 = 3'd1,
		CFG_PRIO_VM2 = 3'd2,
		CFG_PRIO_VM3 = 3'd3,
		CFG_PRIO_VM4 = 3'd4
	} cfg_idx_t;

	// field widths
	localparam int OP_W     = 2;
	localparam int VM_ID_W  = 3;
	localparam int US_W     = 32;
	localparam int WAIT_W   = 14;
	localparam int PERIOD_W = 7;
	localparam int PRIO_W   = 8;
	localparam int TPRIO_W  = 10;
	localparam int USED_W   = 48;
	localparam int TOTAL_W  = 50;
	localparam int WIN_W    = 30;
	localparam int DELAY_W  = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_PRIO_N = 4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd10;
	localparam logic [PRIO_W-1:0]   PRIO_RESET   = 8'd1;

	// moving window of recent consumptions
	localparam int WIN_LEN = 5;
	localparam int POS_W   = $clog2(WIN_LEN);
	localparam logic [POS_W-1:0] WIN_LAST = POS_W'(WIN_LEN - 1);

	// time constants
	localparam int US_PER_MS    = 1000;
	localparam int SLICE_PER_MS = US_PER_MS / WIN_LEN;
	localparam logic [WAIT_W-1:0] WAIT_MIN = 14'd500;
	localparam logic [WAIT_W-1:0] WAIT_MAX = 14'd10000;

	// x / 5 for any 32-bit x: (x * RECIP5) >> RECIP5_SHIFT
	localparam logic [US_W-1:0] RECIP5       = 32'hCCCC_CCCD;
	localparam int              RECIP5_SHIFT = 34;

	typedef struct packed {
		logic [PERIOD_W-1:0]                  period_ms;
		logic [CFG_PRIO_N-1:0][PRIO_W-1:0]    prio;
	} cfg_t;

	typedef struct packed {
		op_t                 operation;
		logic [VM_ID_W-1:0]  vm_id;
		logic [US_W-1:0]     consumed_us;
		logic [WIN_W-1:0]    slice;
	} item_t;

	typedef struct packed {
		logic               grant;
		logic [WAIT_W-1:0]  wait_us;
		logic               error;
	} result_t;

endpackage

// ===== design/psdt_cmd_if.sv =====
// psdt_cmd_if: valid/ready channel that carries command beats into the gate.
// Depends on psdt_pkg for field widths.
interface psdt_cmd_if;
	import psdt_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [VM_ID_W-1:0]  vm_id;
	logic [US_W-1:0]     consumed_us;

	modport source(output valid, operation, vm_id, consumed_us, input ready);
	modport sink(input valid, operation, vm_id, consumed_us, output ready);
endinterface

// ===== design/psdt_rsp_if.sv =====
// psdt_rsp_if: valid/ready channel that carries result beats out of the gate.
// Depends on psdt_pkg for field widths.
interface psdt_rsp_if;
	import psdt_pkg::*;

	logic               valid;
	logic               ready;
	logic               grant;
	logic [WAIT_W-1:0]  wait_us;
	logic               error;

	modport source(output valid, grant, wait_us, error, input ready);
	modport sink(input valid, grant, wait_us, error, output ready);
endinterface

// ===== design/psdt_core.sv =====
// psdt_core: per-machine share state and the single-pass update/check logic.
// Depends on psdt_pkg; driven by the staged command in the top level.
module psdt_core #(
	parameter int NUM_VMS  = 4,
	parameter int MAX_APPS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  psdt_pkg::item_t   item,
	input  psdt_pkg::cfg_t    cfg,
	output psdt_pkg::result_t result
);
	import psdt_pkg::*;

	localparam int VM_W   = (NUM_VMS > 1) ? $clog2(NUM_VMS) : 1;
	localparam int LIVE_W = $clog2(MAX_APPS + 1);
	localparam logic [LIVE_W-1:0] LIVE_MAX = LIVE_W'(MAX_APPS);
	localparam logic [LIVE_W-1:0] LIVE_ONE = LIVE_W'(1);
	localparam int SUM_W  = DELAY_W + 2;

	// per-machine state
	logic [LIVE_W-1:0]  live_q   [NUM_VMS];
	logic [PRIO_W-1:0]  prio_q   [NUM_VMS];
	logic [USED_W-1:0]  used_q   [NUM_VMS];
	logic [POS_W-1:0]   wpos_q   [NUM_VMS];
	logic [DELAY_W-1:0] delay_q  [NUM_VMS];
	logic [WIN_W-1:0]   window_q [NUM_VMS][WIN_LEN];
	// global totals
	logic [TPRIO_W-1:0] tprio_q;
	logic [TOTAL_W-1:0] total_q;

	logic               vm_ok;
	logic [VM_W-1:0]    m;
	logic [LIVE_W-1:0]  cur_live;
	logic [PRIO_W-1:0]  cur_prio;
	logic [USED_W-1:0]  cur_used;
	logic [POS_W-1:0]   cur_pos;
	logic [DELAY_W-1:0] cur_delay;
	logic [POS_W-1:0]   pos_c;
	logic [POS_W-1:0]   pos_next;
	logic [WIN_W-1:0]   win_cur;
	logic [PRIO_W-1:0]  prio_sel;

	logic [WIN_W-1:0]   win_seed;
	logic [DELAY_W-1:0] delay_seed;
	logic [TPRIO_W-1:0] tprio_add;
	logic [TPRIO_W-1:0] tprio_sub;
	logic [TOTAL_W-1:0] total_sub;
	logic [USED_W:0]    used_sum;
	logic [USED_W-1:0]  used_sat;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_sat;
	logic [SUM_W-1:0]   delay_sum;
	logic [SUM_W-1:0]   delay_diff;
	logic [DELAY_W-1:0] delay_n;

	logic [USED_W+TPRIO_W-1:0] lhs;
	logic [TOTAL_W+PRIO_W-1:0] rhs;
	logic [DELAY_W-2:0]        half_delay;
	logic [WAIT_W-1:0]         wait_clamp;

	logic               live_we;
	logic [LIVE_W-1:0]  live_n;
	logic               start_first;
	logic               end_last;
	logic               consume_we;

	// machine select
	assign vm_ok = (item.vm_id != '0) && (item.vm_id <= VM_ID_W'(NUM_VMS));
	assign m     = VM_W'(item.vm_id - VM_ID_W'(1));

	assign cur_live  = live_q[m];
	assign cur_prio  = prio_q[m];
	assign cur_used  = used_q[m];
	assign cur_pos   = wpos_q[m];
	assign cur_delay = delay_q[m];
	assign prio_sel  = cfg.prio[m];

	assign pos_c    = (cur_pos > WIN_LAST) ? '0 : cur_pos;
	assign pos_next = (pos_c == WIN_LAST) ? '0 : pos_c + POS_W'(1);
	assign win_cur  = window_q[m][pos_c];

	// first start: window seeded with period/5, average with period
	assign win_seed   = WIN_W'(cfg.period_ms * 15'(SLICE_PER_MS));
	assign delay_seed = DELAY_W'(cfg.period_ms * 17'(US_PER_MS));

	// weight totals wrap on add, stop at zero on remove
	assign tprio_add = tprio_q + TPRIO_W'(prio_sel);
	assign tprio_sub = (tprio_q >= TPRIO_W'(cur_prio)) ? tprio_q - TPRIO_W'(cur_prio) : '0;
	assign total_sub = (total_q >= TOTAL_W'(cur_used)) ? total_q - TOTAL_W'(cur_used) : '0;

	// saturating accumulators
	assign used_sum  = {1'b0, cur_used} + (USED_W+1)'(item.consumed_us);
	assign used_sat  = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(item.consumed_us);
	assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

	// windowed average: add new slice, drop the oldest, clamp to 32 bits
	assign delay_sum  = SUM_W'(cur_delay) + SUM_W'(item.slice);
	assign delay_diff = delay_sum - SUM_W'(win_cur);
	always_comb begin
		if (delay_sum < SUM_W'(win_cur)) begin
			delay_n = '0;
		end else if (delay_diff[SUM_W-1:DELAY_W] != '0) begin
			delay_n = '1;
		end else begin
			delay_n = delay_diff[DELAY_W-1:0];
		end
	end

	// budget check
	assign lhs        = cur_used * tprio_q;
	assign rhs        = total_q * cur_prio;
	assign half_delay = cur_delay[DELAY_W-1:1];
	always_comb begin
		if (half_delay > (DELAY_W-1)'(WAIT_MAX)) begin
			wait_clamp = WAIT_MAX;
		end else if (half_delay < (DELAY_W-1)'(WAIT_MIN)) begin
			wait_clamp = WAIT_MIN;
		end else begin
			wait_clamp = half_delay[WAIT_W-1:0];
		end
	end

	// operation decode
	always_comb begin
		result      = '0;
		live_we     = 1'b0;
		live_n      = cur_live;
		start_first = 1'b0;
		end_last    = 1'b0;
		consume_we  = 1'b0;
		if (!vm_ok) begin
			result.error = 1'b1;
		end else begin
			unique case (item.operation)
				OP_START: begin
					if (cur_live >= LIVE_MAX) begin
						result.error = 1'b1;
					end else begin
						live_we     = 1'b1;
						live_n      = cur_live + LIVE_ONE;
						start_first = (cur_live == '0);
					end
				end
				OP_END: begin
					if (cur_live == '0) begin
						result.error = 1'b1;
					end else begin
						live_we  = 1'b1;
						live_n   = cur_live - LIVE_ONE;
						end_last = (cur_live == LIVE_ONE);
					end
				end
				OP_CONSUME: begin
					consume_we = 1'b1;
				end
				OP_CHECK: begin
					if (lhs <= rhs) begin
						result.grant = 1'b1;
					end else begin
						result.wait_us = wait_clamp;
					end
				end
			endcase
		end
	end

	// state update, one machine per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tprio_q <= '0;
			total_q <= '0;
			for (int v = 0; v < NUM_VMS; v++) begin
				live_q[v]  <= '0;
				prio_q[v]  <= '0;
				used_q[v]  <= '0;
				wpos_q[v]  <= '0;
				delay_q[v] <= '0;
				for (int w = 0; w < WIN_LEN; w++) begin
					window_q[v][w] <= '0;
				end
			end
		end else if (fire) begin
			if (live_we) begin
				live_q[m] <= live_n;
			end
			if (start_first) begin
				prio_q[m]  <= prio_sel;
				tprio_q    <= tprio_add;
				used_q[m]  <= '0;
				wpos_q[m]  <= '0;
				delay_q[m] <= delay_seed;
				for (int w = 0; w < WIN_LEN; w++) begin
					window_q[m][w] <= win_seed;
				end
			end
			if (end_last) begin
				prio_q[m] <= '0;
				tprio_q   <= tprio_sub;
				total_q   <= total_sub;
				used_q[m] <= '0;
			end
			if (consume_we) begin
				used_q[m]          <= used_sat;
				total_q            <= total_sat;
				delay_q[m]         <= delay_n;
				window_q[m][pos_c] <= item.slice;
				wpos_q[m]          <= pos_next;
			end
		end
	end

endmodule

// ===== design/proportional_share_device_time.sv =====
// Proportional-share gate for device time: command register, state/check pass, result register.
// An accepted command is held in the command register, checked, and its result is registered.
// Throughput: one command per cycle while results are taken;
// all state for a machine updates in one pass; a waiting result still lets stage 1 fill.
// Reset (arst_n low, asynchronous): all machine state and totals clear at once,
// registers return to period 10 ms and weights 1; no clearing sweep.
module proportional_share_device_time #(
	parameter int NUM_VMS  = 4,
	parameter int MAX_APPS = 255
) (
	input  logic                            clk,
	input  logic                            arst_n,
	psdt_cmd_if.sink                        cmd,
	psdt_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [psdt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import psdt_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	item_t              item_s1;
	logic               rsp_valid_q;
	result_t            res_q;
	result_t            core_res;
	logic               advance;
	logic               fire;
	logic [2*US_W-1:0]  slice_prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ms <= PERIOD_RESET;
			for (int i = 0; i < CFG_PRIO_N; i++) begin
				cfg_q.prio[i] <= PRIO_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_PERIOD:   cfg_q.period_ms <= cfg_wdata[PERIOD_W-1:0];
				CFG_PRIO_VM1: cfg_q.prio[0]   <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_VM2: cfg_q.prio[1]   <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_VM3: cfg_q.prio[2]   <= cfg_wdata[PRIO_W-1:0];
				CFG_PRIO_VM4: cfg_q.prio[3]   <= cfg_wdata[PRIO_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or draining
	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	// window slice of the consumed time, divided by five on the way in
	assign slice_prod = cmd.consumed_us * RECIP5;

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.operation   <= op_t'(cmd.operation);
			item_s1.vm_id       <= cmd.vm_id;
			item_s1.consumed_us <= cmd.consumed_us;
			item_s1.slice       <= slice_prod[RECIP5_SHIFT +: WIN_W];
		end
	end

	psdt_core #(
		.NUM_VMS  (NUM_VMS),
		.MAX_APPS (MAX_APPS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.grant   = res_q.grant;
	assign rsp.wait_us = res_q.wait_us;
	assign rsp.error   = res_q.error;

`ifndef SYNTHESIS
	// an accepted command beat lands in stage 1
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> valid_s1)
		else $error("accepted command did not reach stage 1");

	// a blocked stage 1 keeps its command
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 lost its command while blocked");

	// a new result beat always comes from a staged command
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(valid_s1))
		else $error("result beat without a staged command");
`endif

endmodule
